### rtl/core/msie_pkg.sv
// ----------------------------------------------------------------------------
// msie_pkg
// Shared types and constants of the MIPS subset instruction executor.
// ----------------------------------------------------------------------------
package msie_pkg;

	// item kinds carried on the input tuser
	localparam logic [1:0] FUNC_EXEC    = 2'd0;
	localparam logic [1:0] FUNC_PRELOAD = 2'd1;
	localparam logic [1:0] FUNC_READ    = 2'd2;

	// syscall request codes
	localparam logic [1:0] SYS_NONE      = 2'd0;
	localparam logic [1:0] SYS_PRINT_INT = 2'd1;
	localparam logic [1:0] SYS_PRINT_STR = 2'd2;
	localparam logic [1:0] SYS_READ_INT  = 2'd3;

	// syscall service numbers in v0
	localparam logic [31:0] SVC_PRINT_INT = 32'd1;
	localparam logic [31:0] SVC_PRINT_STR = 32'd4;
	localparam logic [31:0] SVC_READ_INT  = 32'd5;

	// opcodes
	localparam logic [5:0] OP_RTYPE = 6'h00;
	localparam logic [5:0] OP_J     = 6'h02;
	localparam logic [5:0] OP_JAL   = 6'h03;
	localparam logic [5:0] OP_BEQ   = 6'h04;
	localparam logic [5:0] OP_BNE   = 6'h05;
	localparam logic [5:0] OP_ADDI  = 6'h08;
	localparam logic [5:0] OP_ADDIU = 6'h09;
	localparam logic [5:0] OP_SLTI  = 6'h0A;
	localparam logic [5:0] OP_SLTIU = 6'h0B;
	localparam logic [5:0] OP_ANDI  = 6'h0C;
	localparam logic [5:0] OP_ORI   = 6'h0D;
	localparam logic [5:0] OP_LUI   = 6'h0F;
	localparam logic [5:0] OP_LW    = 6'h23;
	localparam logic [5:0] OP_SW    = 6'h2B;

	// r-type function codes
	localparam logic [5:0] FN_SLL     = 6'h00;
	localparam logic [5:0] FN_SRL     = 6'h02;
	localparam logic [5:0] FN_JR      = 6'h08;
	localparam logic [5:0] FN_SYSCALL = 6'h0C;
	localparam logic [5:0] FN_ADD     = 6'h20;
	localparam logic [5:0] FN_ADDU    = 6'h21;
	localparam logic [5:0] FN_SUB     = 6'h22;
	localparam logic [5:0] FN_SUBU    = 6'h23;
	localparam logic [5:0] FN_AND     = 6'h24;
	localparam logic [5:0] FN_OR      = 6'h25;
	localparam logic [5:0] FN_SLT     = 6'h2A;
	localparam logic [5:0] FN_SLTU    = 6'h2B;

	// fixed register numbers
	localparam logic [4:0] REG_ZERO = 5'd0;
	localparam logic [4:0] REG_V0   = 5'd2;
	localparam logic [4:0] REG_A0   = 5'd4;
	localparam logic [4:0] REG_RA   = 5'd31;

	// start of the data segment
	localparam logic [31:0] DATA_BASE = 32'h1000_0000;

	typedef enum logic [1:0] {
		MEM_NONE,
		MEM_LOAD,
		MEM_STORE
	} mem_op_t;

	// decoded effect of one instruction
	typedef struct packed {
		logic        wr_en;
		logic [4:0]  wr_addr;
		logic [31:0] wr_data;
		logic        unknown;
		logic        use_target;
		logic [31:0] target;
		mem_op_t     mem_op;
		logic [31:0] mem_addr;
		logic [1:0]  req;
		logic [31:0] sval;
	} exec_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_RUN,
		ST_MOD,
		ST_LOAD,
		ST_STORE,
		ST_FIN
	} state_t;

endpackage

### rtl/core/mips_subset_instruction_executor.sv
// ----------------------------------------------------------------------------
// mips_subset_instruction_executor
// Runs one MIPS32 subset instruction, data preload or register read per item
// against a register file, a big-endian byte data memory and a program counter.
// ----------------------------------------------------------------------------
//  channel | group               | tuser        | tdata (lowest bit up)
//  --------+---------------------+--------------+------------------------------
//  input   | s_tvalid/s_tready   | func         | instr_word, byte_addr,
//          |                     |              | byte_value, reg_select
//  output  | m_tvalid/m_tready   | sys_request  | next_pc, halted, sys_value,
//          |                     |              | reg_value
//
//  alu ops, not-taken branches, register reads: complete straight from the run state
//  jumps, taken branches, preloads: through a modulo unit and a finish state;
//  lw and sw add a load or store state that moves the word a byte at a time
//  on a byte-wide port of the data memory
//  after reset a clearing pass fills every byte of the data memory with 0xFF;
//  no item is taken meanwhile
//  a stalled output holds its result while one further item waits at the input
// ----------------------------------------------------------------------------
module mips_subset_instruction_executor #(
	parameter int DMEM_BYTES = 65536,
	parameter int IMEM_WORDS = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,  // func
	input  logic [63:0] s_tdata,  // instr_word, byte_addr, byte_value, reg_select
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [1:0]  m_tuser,  // sys_request
	output logic [79:0] m_tdata   // next_pc, halted, sys_value, reg_value
);

	localparam int DAW = $clog2(DMEM_BYTES);
	localparam int PCW = $clog2(IMEM_WORDS);

	msie_pkg::state_t state_q;
	msie_pkg::state_t state_d;
	msie_pkg::exec_t  ex;

	// input stage
	logic        s1_valid_q;
	logic [1:0]  func_s1;
	logic [31:0] instr_s1;
	logic [15:0] baddr_s1;
	logic [7:0]  bval_s1;
	logic [4:0]  raddr_a_s1;
	logic [4:0]  raddr_b_s1;
	logic        rva_s1;
	logic        rvb_s1;

	// architectural state
	logic [PCW-1:0] pc_q;
	logic           halt_q;
	logic [31:0]    v0_q;
	logic [31:0]    a0_q;
	logic [31:0]    rvalid_q;

	// last register write, for the read issued in the same cycle
	logic        fwd_we_q;
	logic [4:0]  fwd_addr_q;
	logic [31:0] fwd_data_q;

	// sequencing
	logic [DAW-1:0] clr_cnt_q;
	logic [DAW-1:0] daddr_q;
	logic [DAW-1:0] daddr_inc;
	logic [PCW-1:0] pc_tgt_q;
	logic [2:0]     cnt_q;
	logic [31:0]    ld_q;

	// output register
	logic        m_tvalid_q;
	logic [1:0]  m_tuser_q;
	logic [79:0] m_tdata_q;

	logic           s_fire;
	logic           out_free;
	logic           exec_ok;
	logic           run_known;
	logic           needs_mod;
	logic           complete;
	logic [31:0]    op_a;
	logic [31:0]    op_b;
	logic [31:0]    rd_a;
	logic [31:0]    rd_b;
	logic [4:0]     in_raddr_a;
	logic [4:0]     in_raddr_b;
	logic [PCW-1:0] pc_seq;
	logic [31:0]    pc_inc32;
	logic [PCW-1:0] pc_next;
	logic [31:0]    pc_next32;
	logic           reg_we;
	logic [31:0]    reg_wdata;

	logic           dmod_start;
	logic [31:0]    dmod_value;
	logic           dmod_done;
	logic [DAW-1:0] dmod_res;
	logic           pmod_start;
	logic           pmod_done;
	logic [PCW-1:0] pmod_res;

	logic           dm_we;
	logic [DAW-1:0] dm_waddr;
	logic [7:0]     dm_wdata;
	logic           dm_re;
	logic [7:0]     dm_rdata;

	assign s_fire   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// read ports of the register file are addressed straight from the item
	assign in_raddr_a = (s_tuser == msie_pkg::FUNC_READ) ? s_tdata[60:56] : s_tdata[25:21];
	assign in_raddr_b = s_tdata[20:16];

	// operands with bypass of the write done as this item was taken
	assign op_a = (fwd_we_q && fwd_addr_q == raddr_a_s1) ? fwd_data_q :
		(rva_s1 ? rd_a : 32'd0);
	assign op_b = (fwd_we_q && fwd_addr_q == raddr_b_s1) ? fwd_data_q :
		(rvb_s1 ? rd_b : 32'd0);

	// sequential program counter
	assign pc_inc32 = 32'(pc_q) + 32'd1;
	assign pc_seq   = (pc_q == PCW'(IMEM_WORDS - 1)) ? '0 : pc_q + PCW'(1);

	assign daddr_inc = (daddr_q == DAW'(DMEM_BYTES - 1)) ? '0 : daddr_q + DAW'(1);

	msie_exec u_exec (
		.instr  (instr_s1),
		.op_a   (op_a),
		.op_b   (op_b),
		.v0     (v0_q),
		.a0     (a0_q),
		.pc_inc (pc_inc32),
		.pc_seq (32'(pc_seq)),
		.ex     (ex)
	);

	assign exec_ok   = (func_s1 == msie_pkg::FUNC_EXEC) && !halt_q;
	assign run_known = exec_ok && !ex.unknown;
	assign needs_mod = (func_s1 == msie_pkg::FUNC_PRELOAD) ||
		(run_known && (ex.mem_op != msie_pkg::MEM_NONE || ex.use_target));

	// control outputs of the sequencer
	always_comb begin
		s_tready   = 1'b0;
		complete   = 1'b0;
		dmod_start = 1'b0;
		pmod_start = 1'b0;
		dm_we      = 1'b0;
		dm_waddr   = daddr_q;
		dm_wdata   = bval_s1;
		dm_re      = 1'b0;
		case (state_q)
			msie_pkg::ST_CLEAR: begin
				dm_we    = 1'b1;
				dm_waddr = clr_cnt_q;
				dm_wdata = 8'hFF;
			end
			msie_pkg::ST_RUN: begin
				if (s1_valid_q) begin
					if (needs_mod) begin
						dmod_start = (func_s1 == msie_pkg::FUNC_PRELOAD) ||
							(ex.mem_op != msie_pkg::MEM_NONE);
						pmod_start = !dmod_start;
					end else begin
						complete = out_free;
					end
				end
				s_tready = !s1_valid_q || complete;
			end
			msie_pkg::ST_LOAD: dm_re = (cnt_q < 3'd4);
			msie_pkg::ST_STORE: begin
				dm_we    = 1'b1;
				dm_wdata = 8'(op_b >> {~cnt_q[1:0], 3'b000});
			end
			msie_pkg::ST_FIN: begin
				complete = out_free;
				s_tready = complete;
				dm_we    = complete && (func_s1 == msie_pkg::FUNC_PRELOAD);
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			msie_pkg::ST_CLEAR: begin
				if (clr_cnt_q == DAW'(DMEM_BYTES - 1)) state_d = msie_pkg::ST_RUN;
			end
			msie_pkg::ST_RUN: begin
				if (dmod_start || pmod_start) state_d = msie_pkg::ST_MOD;
			end
			msie_pkg::ST_MOD: begin
				if (pmod_done) begin
					state_d = msie_pkg::ST_FIN;
				end else if (dmod_done) begin
					if (func_s1 == msie_pkg::FUNC_PRELOAD) begin
						state_d = msie_pkg::ST_FIN;
					end else if (ex.mem_op == msie_pkg::MEM_LOAD) begin
						state_d = msie_pkg::ST_LOAD;
					end else begin
						state_d = msie_pkg::ST_STORE;
					end
				end
			end
			msie_pkg::ST_LOAD: begin
				if (cnt_q == 3'd4) state_d = msie_pkg::ST_FIN;
			end
			msie_pkg::ST_STORE: begin
				if (cnt_q == 3'd3) state_d = msie_pkg::ST_FIN;
			end
			msie_pkg::ST_FIN: begin
				if (complete) state_d = msie_pkg::ST_RUN;
			end
			default: state_d = msie_pkg::ST_RUN;
		endcase
	end

	assign dmod_value = (func_s1 == msie_pkg::FUNC_PRELOAD) ? {16'h0000, baddr_s1} :
		ex.mem_addr;

	msie_mod #(.MOD(DMEM_BYTES)) u_dmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dmod_start),
		.value  (dmod_value),
		.done   (dmod_done),
		.result (dmod_res)
	);

	msie_mod #(.MOD(IMEM_WORDS)) u_pmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pmod_start),
		.value  (ex.target),
		.done   (pmod_done),
		.result (pmod_res)
	);

	// effects of a completing item
	assign reg_we    = complete && run_known && ex.wr_en;
	assign reg_wdata = (ex.mem_op == msie_pkg::MEM_LOAD) ? ld_q : ex.wr_data;

	always_comb begin
		pc_next = pc_q;
		if (exec_ok) begin
			if (!ex.unknown && ex.use_target) begin
				pc_next = pc_tgt_q;
			end else begin
				pc_next = pc_seq;
			end
		end
	end
	assign pc_next32 = 32'(pc_next);

	msie_ram #(.WIDTH(8), .DEPTH(DMEM_BYTES)) u_dmem (
		.clk   (clk),
		.we    (dm_we),
		.waddr (dm_waddr),
		.wdata (dm_wdata),
		.re    (dm_re),
		.raddr (daddr_q),
		.rdata (dm_rdata)
	);

	msie_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
		.clk   (clk),
		.we    (reg_we),
		.waddr (ex.wr_addr),
		.wdata (reg_wdata),
		.re    (s_fire),
		.raddr (in_raddr_a),
		.rdata (rd_a)
	);

	msie_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
		.clk   (clk),
		.we    (reg_we),
		.waddr (ex.wr_addr),
		.wdata (reg_wdata),
		.re    (s_fire),
		.raddr (in_raddr_b),
		.rdata (rd_b)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= msie_pkg::ST_CLEAR;
			s1_valid_q <= 1'b0;
			pc_q       <= '0;
			halt_q     <= 1'b0;
			v0_q       <= '0;
			a0_q       <= '0;
			rvalid_q   <= '0;
			fwd_we_q   <= 1'b0;
			clr_cnt_q  <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == msie_pkg::ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + DAW'(1);
			end
			if (s_fire) begin
				s1_valid_q <= 1'b1;
			end else if (complete) begin
				s1_valid_q <= 1'b0;
			end
			// byte counter for load and store
			if (state_q == msie_pkg::ST_LOAD) begin
				cnt_q <= (cnt_q == 3'd4) ? 3'd0 : cnt_q + 3'd1;
			end else if (state_q == msie_pkg::ST_STORE) begin
				cnt_q <= (cnt_q == 3'd3) ? 3'd0 : cnt_q + 3'd1;
			end
			if (complete) begin
				pc_q     <= pc_next;
				fwd_we_q <= reg_we;
				if (exec_ok && ex.unknown) begin
					halt_q <= 1'b1;
				end
				if (reg_we) begin
					rvalid_q[ex.wr_addr] <= 1'b1;
					if (ex.wr_addr == msie_pkg::REG_V0) v0_q <= reg_wdata;
					if (ex.wr_addr == msie_pkg::REG_A0) a0_q <= reg_wdata;
				end
			end
			if (out_free) begin
				m_tvalid_q <= complete;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_fire) begin
			func_s1    <= s_tuser;
			instr_s1   <= s_tdata[31:0];
			baddr_s1   <= s_tdata[47:32];
			bval_s1    <= s_tdata[55:48];
			raddr_a_s1 <= in_raddr_a;
			raddr_b_s1 <= in_raddr_b;
			rva_s1     <= rvalid_q[in_raddr_a];
			rvb_s1     <= rvalid_q[in_raddr_b];
		end
		if (complete) begin
			fwd_addr_q <= ex.wr_addr;
			fwd_data_q <= reg_wdata;
		end
		if (dmod_done) begin
			daddr_q <= dmod_res;
		end else if (state_q == msie_pkg::ST_STORE ||
			(state_q == msie_pkg::ST_LOAD && cnt_q < 3'd4)) begin
			daddr_q <= daddr_inc;
		end
		if (pmod_done) begin
			pc_tgt_q <= pmod_res;
		end
		// big-endian assembly, first byte read ends up on top
		if (state_q == msie_pkg::ST_LOAD && cnt_q != 3'd0) begin
			ld_q <= {ld_q[23:0], dm_rdata};
		end
		if (complete) begin
			m_tuser_q <= run_known ? ex.req : msie_pkg::SYS_NONE;
			m_tdata_q[13:0]  <= pc_next32[13:0];
			m_tdata_q[14]    <= halt_q || (exec_ok && ex.unknown);
			m_tdata_q[46:15] <= run_known ? ex.sval : 32'd0;
			m_tdata_q[78:47] <= (func_s1 == msie_pkg::FUNC_READ) ? op_a : 32'd0;
			m_tdata_q[79]    <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	// halt is sticky
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt flag cleared");

	// program counter stays inside the instruction space
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pc_q) < 32'(IMEM_WORDS))
		else $error("pc out of range");

	// modulo results only arrive while waiting for them
	a_mod_state: assert property (@(posedge clk) disable iff (!arst_n)
		(dmod_done || pmod_done) |-> state_q == msie_pkg::ST_MOD)
		else $error("modulo result outside wait state");

	// no item is taken during the clearing pass
	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == msie_pkg::ST_CLEAR |-> !s_tready && !s1_valid_q)
		else $error("item taken while clearing");

	// register zero is never written
	a_r0: assert property (@(posedge clk) disable iff (!arst_n)
		reg_we |-> ex.wr_addr != msie_pkg::REG_ZERO)
		else $error("write to register zero");
`endif

endmodule

### rtl/core/msie_ram.sv
// ----------------------------------------------------------------------------
// msie_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module msie_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port, holds when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/msie_mod.sv
// ----------------------------------------------------------------------------
// msie_mod
// Reduces a 32-bit value modulo a constant: a mask for a power of two,
// otherwise a reciprocal multiplication followed by one correction step.
// ----------------------------------------------------------------------------
module msie_mod #(
	parameter int MOD = 65536
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [31:0]            value,
	output logic                   done,
	output logic [$clog2(MOD)-1:0] result
);

	localparam int MW = $clog2(MOD);
	localparam bit POW2 = ((MOD & (MOD - 1)) == 0);

	generate
		if (POW2) begin : g_mask
			logic            done_q;
			logic [MW-1:0]   res_q;

			// low bits are the remainder
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					res_q <= value[MW-1:0];
				end
			end

			assign done   = done_q;
			assign result = res_q;
		end else begin : g_recip
			// floor(2^32 / MOD): the estimate is the quotient or one below it
			localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(MOD));

			logic          done1_q;
			logic          done_q;
			logic [31:0]   val_q;
			logic [31:0]   quo_q;
			logic [MW-1:0] rem_q;
			logic [31:0]   quo;
			logic [31:0]   rem_est;

			// quotient estimate from the high half of the reciprocal product
			assign quo = 32'(({32'd0, value} * {32'd0, RECIP}) >> 32);

			// remainder estimate, below twice the modulus
			assign rem_est = val_q - quo_q * 32'(MOD);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done1_q <= 1'b0;
					done_q  <= 1'b0;
				end else begin
					done1_q <= start;
					done_q  <= done1_q;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					val_q <= value;
					quo_q <= quo;
				end
				// one correction step
				if (done1_q) begin
					if (rem_est >= 32'(MOD)) begin
						rem_q <= MW'(rem_est - 32'(MOD));
					end else begin
						rem_q <= rem_est[MW-1:0];
					end
				end
			end

			assign done   = done_q;
			assign result = rem_q;
		end
	endgenerate

endmodule

### rtl/core/msie_exec.sv
// ----------------------------------------------------------------------------
// msie_exec
// Decodes one instruction word and computes its register, branch, memory
// and syscall effects from the operand values.
// ----------------------------------------------------------------------------
module msie_exec (
	input  logic [31:0]     instr,
	input  logic [31:0]     op_a,
	input  logic [31:0]     op_b,
	input  logic [31:0]     v0,
	input  logic [31:0]     a0,
	input  logic [31:0]     pc_inc,
	input  logic [31:0]     pc_seq,
	output msie_pkg::exec_t ex
);

	logic [5:0]  op;
	logic [4:0]  rt;
	logic [4:0]  rd;
	logic [4:0]  sh;
	logic [5:0]  fn;
	logic [31:0] zimm;
	logic [31:0] simm;
	logic [31:0] wdata;
	logic [4:0]  waddr;
	logic        wen;

	// instruction fields
	assign op   = instr[31:26];
	assign rt   = instr[20:16];
	assign rd   = instr[15:11];
	assign sh   = instr[10:6];
	assign fn   = instr[5:0];
	assign zimm = {16'h0000, instr[15:0]};
	assign simm = {{16{instr[15]}}, instr[15:0]};

	// decode and execute
	always_comb begin
		wen           = 1'b0;
		waddr         = rd;
		wdata         = '0;
		ex            = '0;
		ex.mem_op     = msie_pkg::MEM_NONE;
		ex.req        = msie_pkg::SYS_NONE;
		ex.mem_addr   = op_a + simm - msie_pkg::DATA_BASE;
		ex.target     = pc_inc + simm;
		case (op)
			msie_pkg::OP_RTYPE: begin
				case (fn)
					msie_pkg::FN_ADD, msie_pkg::FN_ADDU: begin
						wen   = 1'b1;
						wdata = op_a + op_b;
					end
					msie_pkg::FN_SUB, msie_pkg::FN_SUBU: begin
						wen   = 1'b1;
						wdata = op_a - op_b;
					end
					msie_pkg::FN_AND: begin
						wen   = 1'b1;
						wdata = op_a & op_b;
					end
					msie_pkg::FN_OR: begin
						wen   = 1'b1;
						wdata = op_a | op_b;
					end
					msie_pkg::FN_SLT: begin
						wen   = 1'b1;
						wdata = {31'd0, $signed(op_a) < $signed(op_b)};
					end
					msie_pkg::FN_SLTU: begin
						wen   = 1'b1;
						wdata = {31'd0, op_a < op_b};
					end
					msie_pkg::FN_SLL: begin
						wen   = 1'b1;
						wdata = op_b << sh;
					end
					msie_pkg::FN_SRL: begin
						wen   = 1'b1;
						wdata = op_b >> sh;
					end
					msie_pkg::FN_JR: begin
						ex.use_target = 1'b1;
						ex.target     = {2'b00, op_a[31:2]};
					end
					msie_pkg::FN_SYSCALL: begin
						ex.sval = a0;
						if (v0 == msie_pkg::SVC_PRINT_INT) begin
							ex.req = msie_pkg::SYS_PRINT_INT;
						end else if (v0 == msie_pkg::SVC_PRINT_STR) begin
							ex.req = msie_pkg::SYS_PRINT_STR;
						end else if (v0 == msie_pkg::SVC_READ_INT) begin
							ex.req = msie_pkg::SYS_READ_INT;
						end else begin
							ex.unknown = 1'b1;
							ex.sval    = '0;
						end
					end
					default: ex.unknown = 1'b1;
				endcase
			end
			msie_pkg::OP_J: begin
				ex.use_target = 1'b1;
				ex.target     = {6'd0, instr[25:0]};
			end
			msie_pkg::OP_JAL: begin
				wen           = 1'b1;
				waddr         = msie_pkg::REG_RA;
				wdata         = {pc_seq[29:0], 2'b00};
				ex.use_target = 1'b1;
				ex.target     = {6'd0, instr[25:0]};
			end
			msie_pkg::OP_ADDI, msie_pkg::OP_ADDIU: begin
				wen   = 1'b1;
				waddr = rt;
				wdata = op_a + simm;
			end
			msie_pkg::OP_ANDI: begin
				wen   = 1'b1;
				waddr = rt;
				wdata = op_a & zimm;
			end
			msie_pkg::OP_ORI: begin
				wen   = 1'b1;
				waddr = rt;
				wdata = op_a | zimm;
			end
			msie_pkg::OP_SLTI: begin
				wen   = 1'b1;
				waddr = rt;
				wdata = {31'd0, $signed(op_a) < $signed(simm)};
			end
			msie_pkg::OP_SLTIU: begin
				wen   = 1'b1;
				waddr = rt;
				wdata = {31'd0, op_a < simm};
			end
			msie_pkg::OP_LUI: begin
				wen   = 1'b1;
				waddr = rt;
				wdata = {instr[15:0], 16'h0000};
			end
			msie_pkg::OP_BEQ: ex.use_target = (op_a == op_b);
			msie_pkg::OP_BNE: ex.use_target = (op_a != op_b);
			msie_pkg::OP_LW: begin
				wen       = 1'b1;
				waddr     = rt;
				ex.mem_op = msie_pkg::MEM_LOAD;
			end
			msie_pkg::OP_SW: ex.mem_op = msie_pkg::MEM_STORE;
			default: ex.unknown = 1'b1;
		endcase
		// register zero is never written
		ex.wr_en   = wen && (waddr != msie_pkg::REG_ZERO) && !ex.unknown;
		ex.wr_addr = waddr;
		ex.wr_data = wdata;
	end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MIPS subset executor. A behavioral copy of the
// register file, data memory and program counter predicts every result. The
// stimulus is a directed opening, then three phases of random programs with
// varied flow control, and a closing halt sequence.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  CYCLE_LIMIT = 3000000;
	localparam int  DRAIN_CYCLES = 200;
	localparam int  PHASE_ITEMS = 500;

	// item kind with no effect, and encodings that stop the block
	localparam logic [1:0]  FUNC_UNUSED = 2'd3;
	localparam logic [5:0]  OP_BAD_LO   = 6'h10;
	localparam logic [5:0]  OP_BAD_HI   = 6'h13;
	localparam logic [5:0]  FN_BAD      = 6'h3F;
	localparam logic [15:0] SVC_BAD     = 16'h0007;

	typedef struct packed {
		logic [13:0] next_pc;
		logic        halted;
		logic [1:0]  sys_request;
		logic [31:0] sys_value;
		logic [31:0] reg_value;
	} outcome_t;

	// architectural copy of the block and its queue of predicted outcomes
	class cpu_scoreboard;
		logic [31:0] regs [32];
		logic [7:0]  dmem [65536];
		logic [13:0] pc;
		logic        halt;
		outcome_t    pending [$];
		int          mismatches;

		function void clear();
			foreach (regs[i]) regs[i] = '0;
			foreach (dmem[i]) dmem[i] = 8'hFF;
			pc = '0;
			halt = 1'b0;
			mismatches = 0;
		endfunction

		function void put_reg(logic [4:0] r, logic [31:0] v);
			if (r != msie_pkg::REG_ZERO) regs[r] = v;
		endfunction

		// runs one instruction; returns 0 on an unknown one
		function bit run_instr(logic [31:0] w, ref outcome_t o);
			logic [5:0]  op, fn;
			logic [4:0]  rs, rt, rd, sh;
			logic [31:0] imm, simm, a, b, addr, word;
			logic [13:0] nxt;
			op = w[31:26]; fn = w[5:0];
			rs = w[25:21]; rt = w[20:16]; rd = w[15:11]; sh = w[10:6];
			imm = {16'h0, w[15:0]};
			simm = {{16{w[15]}}, w[15:0]};
			a = regs[rs];
			b = regs[rt];
			nxt = pc + 14'd1;
			case (op)
				msie_pkg::OP_RTYPE: begin
					case (fn)
						msie_pkg::FN_ADD, msie_pkg::FN_ADDU: put_reg(rd, a + b);
						msie_pkg::FN_SUB, msie_pkg::FN_SUBU: put_reg(rd, a - b);
						msie_pkg::FN_AND: put_reg(rd, a & b);
						msie_pkg::FN_OR: put_reg(rd, a | b);
						msie_pkg::FN_SLT: put_reg(rd, {31'h0, $signed(a) < $signed(b)});
						msie_pkg::FN_SLTU: put_reg(rd, {31'h0, a < b});
						msie_pkg::FN_SLL: put_reg(rd, b << sh);
						msie_pkg::FN_SRL: put_reg(rd, b >> sh);
						msie_pkg::FN_JR: nxt = a[15:2];
						msie_pkg::FN_SYSCALL: begin
							if (regs[msie_pkg::REG_V0] == msie_pkg::SVC_PRINT_INT)
								o.sys_request = msie_pkg::SYS_PRINT_INT;
							else if (regs[msie_pkg::REG_V0] == msie_pkg::SVC_PRINT_STR)
								o.sys_request = msie_pkg::SYS_PRINT_STR;
							else if (regs[msie_pkg::REG_V0] == msie_pkg::SVC_READ_INT)
								o.sys_request = msie_pkg::SYS_READ_INT;
							else return 0;
							o.sys_value = regs[msie_pkg::REG_A0];
						end
						default: return 0;
					endcase
				end
				msie_pkg::OP_J: nxt = w[13:0];
				msie_pkg::OP_JAL: begin
					put_reg(msie_pkg::REG_RA, {16'h0, nxt, 2'b00});
					nxt = w[13:0];
				end
				msie_pkg::OP_ADDI, msie_pkg::OP_ADDIU: put_reg(rt, a + simm);
				msie_pkg::OP_ANDI: put_reg(rt, a & imm);
				msie_pkg::OP_ORI: put_reg(rt, a | imm);
				msie_pkg::OP_SLTI: put_reg(rt, {31'h0, $signed(a) < $signed(simm)});
				msie_pkg::OP_SLTIU: put_reg(rt, {31'h0, a < simm});
				msie_pkg::OP_LUI: put_reg(rt, {w[15:0], 16'h0});
				msie_pkg::OP_BEQ: if (a == b) nxt = pc + 14'd1 + simm[13:0];
				msie_pkg::OP_BNE: if (a != b) nxt = pc + 14'd1 + simm[13:0];
				msie_pkg::OP_LW: begin
					addr = a + simm - msie_pkg::DATA_BASE;
					for (int k = 0; k < 4; k++)
						word[31 - 8*k -: 8] = dmem[16'(addr[15:0] + k)];
					put_reg(rt, word);
				end
				msie_pkg::OP_SW: begin
					addr = a + simm - msie_pkg::DATA_BASE;
					for (int k = 0; k < 4; k++)
						dmem[16'(addr[15:0] + k)] = b[31 - 8*k -: 8];
				end
				default: return 0;
			endcase
			pc = nxt;
			return 1;
		endfunction

		// predicts the outcome of one accepted item
		function void note_item(logic [1:0] f, logic [31:0] w, logic [15:0] ba,
				logic [7:0] bv, logic [4:0] rsel);
			outcome_t o;
			o = '0;
			if (f == msie_pkg::FUNC_EXEC && !halt) begin
				if (!run_instr(w, o)) begin
					o.sys_request = msie_pkg::SYS_NONE;
					o.sys_value = '0;
					pc = pc + 14'd1;
					halt = 1'b1;
				end
			end else if (f == msie_pkg::FUNC_PRELOAD) begin
				dmem[ba] = bv;
			end else if (f == msie_pkg::FUNC_READ) begin
				o.reg_value = regs[rsel];
			end
			o.next_pc = pc;
			o.halted = halt;
			pending.push_back(o);
		endfunction

		function void check_result(outcome_t got);
			outcome_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
				return;
			end
			want = pending.pop_front();
			if (got.next_pc !== want.next_pc || got.halted !== want.halted ||
					got.sys_request !== want.sys_request ||
					got.sys_value !== want.sys_value || got.reg_value !== want.reg_value) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch pc %h/%h halt %b/%b req %0d/%0d sval %h/%h rval %h/%h",
						want.next_pc, got.next_pc, want.halted, got.halted,
						want.sys_request, got.sys_request, want.sys_value, got.sys_value,
						want.reg_value, got.reg_value);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [1:0]  s_tuser;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [1:0]  m_tuser;
	logic [79:0] m_tdata;

	cpu_scoreboard sb;
	int tx_idle;
	int rx_idle;
	int cycles;

	mips_subset_instruction_executor DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver stalls
	always @(negedge clk) m_tready <= ($urandom_range(99) >= rx_idle);

	// result monitor
	always @(posedge clk) begin
		outcome_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.next_pc = m_tdata[13:0];
			got.halted = m_tdata[14];
			got.sys_value = m_tdata[46:15];
			got.reg_value = m_tdata[78:47];
			got.sys_request = m_tuser;
			sb.check_result(got);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic [31:0] enc_r(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
			logic [4:0] sh, logic [5:0] fn);
		return {msie_pkg::OP_RTYPE, rs, rt, rd, sh, fn};
	endfunction

	function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
			logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	// one item through the input handshake
	task automatic send(logic [1:0] f, logic [31:0] w = '0, logic [15:0] ba = '0,
			logic [7:0] bv = '0, logic [4:0] rsel = '0);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= f;
		s_tdata <= {3'b0, rsel, bv, ba, w};
		do @(posedge clk); while (!s_tready);
		sb.note_item(f, w, ba, bv, rsel);
	endtask

	task automatic exec(logic [31:0] w);
		send(msie_pkg::FUNC_EXEC, w);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	// one random item or short sequence that never hits an unknown instruction
	task automatic random_step();
		logic [5:0]  alu_fn [8] = '{msie_pkg::FN_ADD, msie_pkg::FN_ADDU, msie_pkg::FN_SUB,
			msie_pkg::FN_SUBU, msie_pkg::FN_AND, msie_pkg::FN_OR, msie_pkg::FN_SLT,
			msie_pkg::FN_SLTU};
		logic [5:0]  imm_op [7] = '{msie_pkg::OP_ADDI, msie_pkg::OP_ADDIU, msie_pkg::OP_ANDI,
			msie_pkg::OP_ORI, msie_pkg::OP_SLTI, msie_pkg::OP_SLTIU, msie_pkg::OP_LUI};
		logic [31:0] svc [3] = '{msie_pkg::SVC_PRINT_INT, msie_pkg::SVC_PRINT_STR,
			msie_pkg::SVC_READ_INT};
		logic [31:0] w;
		logic [4:0]  ra, rb, rc;
		int sel;
		w = $urandom;
		ra = 5'($urandom); rb = 5'($urandom); rc = 5'($urandom);
		sel = $urandom_range(99);
		if (sel < 22) exec(enc_r(ra, rb, rc, w[10:6], alu_fn[$urandom_range(7)]));
		else if (sel < 28) exec(enc_r(ra, rb, rc, w[10:6],
			$urandom_range(1) ? msie_pkg::FN_SLL : msie_pkg::FN_SRL));
		else if (sel < 48) exec(enc_i(imm_op[$urandom_range(6)], ra, rb, w[15:0]));
		else if (sel < 58) begin
			// point a base register at the data segment, then access it
			exec(enc_i(msie_pkg::OP_LUI, 5'd0, ra, 16'h1000));
			exec(enc_i($urandom_range(1) ? msie_pkg::OP_LW : msie_pkg::OP_SW, ra, rb,
				$urandom_range(1) ? 16'($urandom_range(64)) : w[15:0]));
		end else if (sel < 64) exec(enc_i($urandom_range(1) ? msie_pkg::OP_LW :
			msie_pkg::OP_SW, ra, rb, w[15:0]));
		else if (sel < 72) exec(enc_i($urandom_range(1) ? msie_pkg::OP_BEQ :
			msie_pkg::OP_BNE, ra, rb, w[15:0]));
		else if (sel < 76) exec({$urandom_range(1) ? msie_pkg::OP_J : msie_pkg::OP_JAL,
			w[25:0]});
		else if (sel < 78) exec(enc_r(ra, w[20:16], w[15:11], w[10:6], msie_pkg::FN_JR));
		else if (sel < 83) begin
			exec(enc_i(msie_pkg::OP_ADDIU, 5'd0, msie_pkg::REG_V0,
				svc[$urandom_range(2)][15:0]));
			exec({msie_pkg::OP_RTYPE, w[25:6], msie_pkg::FN_SYSCALL});
		end else if (sel < 90) send(msie_pkg::FUNC_PRELOAD, $urandom, w[15:0], w[23:16],
			w[28:24]);
		else if (sel < 98) send(msie_pkg::FUNC_READ, $urandom, 16'($urandom),
			8'($urandom), w[4:0]);
		else send(FUNC_UNUSED, w, 16'($urandom), 8'($urandom), 5'($urandom));
	endtask

	initial begin
		sb = new();
		sb.clear();
		cycles = 0;
		tx_idle = 0;
		rx_idle = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = '0;
		s_tdata = '0;
		m_tready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed opening: field extremes, every item kind and a selection of operations
		send(msie_pkg::FUNC_READ, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 5'd31);
		send(msie_pkg::FUNC_PRELOAD, '0, 16'h0000, 8'h00);
		send(msie_pkg::FUNC_PRELOAD, '0, 16'hFFFF, 8'hA5);
		send(FUNC_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 5'd31);
		exec(enc_i(msie_pkg::OP_LUI, 5'd0, 5'd8, 16'h1000));
		exec(enc_i(msie_pkg::OP_ORI, 5'd8, 5'd9, 16'hFFFF));
		exec(enc_i(msie_pkg::OP_ADDIU, 5'd0, 5'd10, 16'hFFFF));
		exec(enc_i(msie_pkg::OP_LUI, 5'd0, 5'd11, 16'h7FFF));
		exec(enc_i(msie_pkg::OP_ADDI, 5'd11, 5'd11, 16'hFFFF));
		exec(enc_r(5'd11, 5'd10, 5'd12, 5'd0, msie_pkg::FN_ADD));
		exec(enc_r(5'd10, 5'd11, 5'd13, 5'd0, msie_pkg::FN_SUB));
		exec(enc_r(5'd10, 5'd11, 5'd14, 5'd0, msie_pkg::FN_SLT));
		exec(enc_r(5'd10, 5'd11, 5'd15, 5'd0, msie_pkg::FN_SLTU));
		exec(enc_r(5'd0, 5'd10, 5'd16, 5'd31, msie_pkg::FN_SLL));
		exec(enc_r(5'd0, 5'd10, 5'd17, 5'd31, msie_pkg::FN_SRL));
		exec(enc_i(msie_pkg::OP_SLTIU, 5'd11, 5'd18, 16'hFFFF));
		exec(enc_i(msie_pkg::OP_SW, 5'd8, 5'd11, 16'hFFFE));
		exec(enc_i(msie_pkg::OP_LW, 5'd8, 5'd19, 16'hFFFD));
		exec(enc_i(msie_pkg::OP_BEQ, 5'd0, 5'd0, 16'h8000));
		exec({msie_pkg::OP_JAL, 26'h3FF_FFFF});
		exec(enc_r(5'd31, 5'd0, 5'd0, 5'd0, msie_pkg::FN_JR));
		exec(enc_i(msie_pkg::OP_ADDIU, 5'd0, msie_pkg::REG_V0,
			msie_pkg::SVC_PRINT_INT[15:0]));
		exec(enc_r(5'd0, 5'd0, 5'd0, 5'd0, msie_pkg::FN_SYSCALL));
		send(msie_pkg::FUNC_READ, '0, '0, '0, 5'd19);

		// random phases with alternating idling
		for (int ph = 0; ph < 3; ph++) begin
			wait_drained();
			tx_idle = (ph == 0) ? 23 : (ph == 1) ? 65 : 0;
			rx_idle = (ph == 0) ? 65 : (ph == 1) ? 23 : 0;
			for (int n = 0; n < PHASE_ITEMS; n++) random_step();
		end

		// halt on an unknown syscall, then unknown encodings are ignored
		exec(enc_i(msie_pkg::OP_ADDIU, 5'd0, msie_pkg::REG_V0, SVC_BAD));
		exec(enc_r(5'd0, 5'd0, 5'd0, 5'd0, msie_pkg::FN_SYSCALL));
		exec({OP_BAD_LO, 26'h3FF_FFFF});
		exec({OP_BAD_HI, 26'h0});
		exec(enc_r(5'd1, 5'd2, 5'd3, 5'd0, FN_BAD));
		exec(enc_i(msie_pkg::OP_ADDIU, 5'd0, 5'd5, 16'h1234));
		send(msie_pkg::FUNC_PRELOAD, '0, 16'h8000, 8'h5A);
		send(msie_pkg::FUNC_READ, '0, '0, '0, 5'd5);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
